/* hw/rtl/shab_pkg.sv */
// shared types, constants and round functions for the sha-256 byte stream hasher
// depends on nothing; used by hw/rtl/sha256_byte_stream_hasher.sv
package shab_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef logic [0:7][31:0] hash_t;

  localparam hash_t InitHash = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PadMark = 8'h80;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sha256_byte_stream_hasher.sv */
// sha-256 hasher over a byte stream: byte collection, padding, round unit, digest output
// depends on hw/rtl/shab_pkg.sv
//
// usage:
//   input channel: one message byte per item (has_byte), or a bare end marker.
//   last_byte ends the message; the block then pads, finishes and sends the digest.
//   output channel: eight items of one 32-bit digest word each, word 0 first,
//   last_word set on word 7.
// flow:
//   a plain byte is taken without a stall. the byte that completes a 64-byte block
//   holds in_stall_o high through 64 rounds of the one shared round unit
//   and the fold of the result into the chaining value.
//   on the last item, padding is shifted into the block one byte per cycle
//   (up to 64 bytes, up to 72 over both blocks when a second block is needed),
//   each padded block then goes through the rounds and the fold, then the eight words
//   follow, one per cycle while out_stall_i is low.
// reset: clears the chaining value to the initial hash, the bit count and all
//   control state; the block starts ready for a new message.
// stall: while out_stall_i is high the current word holds; no new input item
//   is taken until all eight words are delivered.
module sha256_byte_stream_hasher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  shab_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output shab_pkg::out_item_t out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [2:0] PH_NONE = 3'd0;
  localparam logic [2:0] PH_MARK = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [2:0]      phase_q, phase_d;
  logic [5:0]      fill_q, fill_d;
  logic [5:0]      round_q, round_d;
  logic [2:0]      out_idx_q, out_idx_d;
  logic [63:0]     bit_count_q, bit_count_d;
  shab_pkg::hash_t chain_q, chain_d;
  shab_pkg::hash_t vars_q, vars_d;
  logic [511:0]    win_q, win_d;

  logic        in_acc, out_acc;
  logic        len_mode;
  logic [63:0] len_shift;
  logic [7:0]  pad_byte;
  logic [31:0] w_new, t1, t2;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign out_data_o.digest_word = chain_q[out_idx_q];
  assign out_data_o.word_index  = out_idx_q;
  assign out_data_o.last_word   = (out_idx_q == 3'd7);

  // padding byte source
  assign len_mode  = (phase_q == PH_LEN) || ((phase_q == PH_ZERO) && (fill_q == 6'd56));
  assign len_shift = bit_count_q >> {~fill_q[2:0], 3'b000};
  always_comb begin
    if (phase_q == PH_MARK) begin
      pad_byte = shab_pkg::PadMark;
    end else if (len_mode) begin
      pad_byte = len_shift[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // shared round unit, schedule word 0 is the oldest
  assign w_new = shab_pkg::small_sigma1(win_q[511-32*14 -: 32]) + win_q[511-32*9 -: 32]
               + shab_pkg::small_sigma0(win_q[511-32*1 -: 32]) + win_q[511:480];
  assign t1 = vars_q[7] + shab_pkg::big_sigma1(vars_q[4])
            + shab_pkg::choose(vars_q[4], vars_q[5], vars_q[6])
            + shab_pkg::round_k(round_q) + win_q[511:480];
  assign t2 = shab_pkg::big_sigma0(vars_q[0])
            + shab_pkg::majority(vars_q[0], vars_q[1], vars_q[2]);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    round_d     = round_q;
    out_idx_d   = out_idx_q;
    bit_count_d = bit_count_q;
    chain_d     = chain_q;
    vars_d      = vars_q;
    win_d       = win_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.has_byte) begin
            win_d       = {win_q[503:0], in_data_i.data_byte};
            fill_d      = fill_q + 6'd1;
            bit_count_d = bit_count_q + 64'd8;
          end
          if (in_data_i.last_byte) begin
            phase_d = PH_MARK;
          end
          if (in_data_i.has_byte && (fill_q == 6'd63)) begin
            state_d = ST_ROUND;
            round_d = 6'd0;
            vars_d  = chain_q;
          end else if (in_data_i.last_byte) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        win_d  = {win_q[503:0], pad_byte};
        fill_d = fill_q + 6'd1;
        if (phase_q == PH_MARK) begin
          phase_d = PH_ZERO;
        end else if (len_mode) begin
          phase_d = (fill_q == 6'd63) ? PH_DONE : PH_LEN;
        end
        if (fill_q == 6'd63) begin
          state_d = ST_ROUND;
          round_d = 6'd0;
          vars_d  = chain_q;
        end
      end
      ST_ROUND: begin
        win_d     = {win_q[479:0], w_new};
        vars_d[7] = vars_q[6];
        vars_d[6] = vars_q[5];
        vars_d[5] = vars_q[4];
        vars_d[4] = vars_q[3] + t1;
        vars_d[3] = vars_q[2];
        vars_d[2] = vars_q[1];
        vars_d[1] = vars_q[0];
        vars_d[0] = t1 + t2;
        round_d   = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int j = 0; j < 8; j++) begin
          chain_d[j] = chain_q[j] + vars_q[j];
        end
        if (phase_q == PH_DONE) begin
          state_d   = ST_OUT;
          out_idx_d = 3'd0;
        end else if (phase_q == PH_NONE) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == 3'd7) begin
            state_d     = ST_IDLE;
            phase_d     = PH_NONE;
            fill_d      = 6'd0;
            bit_count_d = 64'd0;
            chain_d     = shab_pkg::InitHash;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_NONE;
      fill_q      <= 6'd0;
      round_q     <= 6'd0;
      out_idx_q   <= 3'd0;
      bit_count_q <= 64'd0;
      chain_q     <= shab_pkg::InitHash;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      round_q     <= round_d;
      out_idx_q   <= out_idx_d;
      bit_count_q <= bit_count_d;
      chain_q     <= chain_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    win_q  <= win_d;
  end

endmodule
